// ===== rtl/clock_preset_write_sequencer_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the clock preset write sequencer
// Shared concurrent check templates, clocked on aclk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef CLOCK_PRESET_WRITE_SEQUENCER_DEFINES_SVH
`define CLOCK_PRESET_WRITE_SEQUENCER_DEFINES_SVH

// Same-cycle implication
`define CPWS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define CPWS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cpws_pkg.sv =====
// ----------------------------------------------------------------------------
// cpws_pkg
// Types, constants and helpers shared by the clock preset write sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package cpws_pkg;

    // Result item targets
    typedef enum logic [2:0] {
        TGT_NONE = 3'd0,
        TGT_FREQ = 3'd1,
        TGT_FLL  = 3'd2,
        TGT_WAIT = 3'd3,
        TGT_MRS2 = 3'd4,
        TGT_MRS3 = 3'd5,
        TGT_LOCK = 3'd6
    } target_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_FREQ_CTRL  = 2'd0,
        REG_FLL_FREQ   = 2'd1,
        REG_SDRAM_WAIT = 2'd2,
        REG_SNAP_VALID = 2'd3
    } cfg_reg_t;

    localparam int LEVEL_W   = 3;
    localparam int FLF_W     = 14;
    localparam int RAISED_W  = 15;
    localparam int NUM_W     = 21;
    localparam int QUO_W     = 16;
    localparam int PCT_W     = 16;
    localparam int MAX_ITEMS = 7;
    localparam int CNT_W     = 3;

    localparam logic [LEVEL_W-1:0]  MAX_LEVEL      = 3'd5;
    localparam logic [LEVEL_W-1:0]  LEVEL_DEFAULT  = 3'd0;
    localparam logic [RAISED_W-1:0] FLF_CAP_SINGLE = 15'd1023;
    localparam logic [RAISED_W-1:0] FLF_CAP        = 15'h3FFF;
    localparam logic [21:0]         PCT_SCALE      = 22'd100;

    // Bus frequency thresholds for the minimum row cycle
    localparam logic [NUM_W-1:0] BUS_RC3 = 21'd3479;
    localparam logic [NUM_W-1:0] BUS_RC2 = 21'd2320;
    localparam logic [NUM_W-1:0] BUS_RC1 = 21'd1450;

    localparam logic [31:0] TURBO_WAIT    = 32'h0000_4892;
    localparam logic [31:0] CAS_MASK      = 32'h0000_0180;
    localparam logic [31:0] CAS_CL2_BITS  = 32'h0000_0080;
    localparam logic [31:0] FLL_LOW_MASK  = 32'h0000_7FFF;
    localparam logic [31:0] FLF_MASK      = 32'h0000_3FFF;
    localparam logic [31:0] FLL_DBL_BIT   = 32'h0000_4000;

    localparam logic [1:0] CAS_CODE_CL2 = 2'd1;
    localparam logic [1:0] CAS_CODE_CL3 = 2'd2;

    localparam logic [PCT_W-1:0] PCT_DEFAULT = 16'd100;
    localparam logic [PCT_W-1:0] PCT_TURBO   = 16'd200;

    // Sideband that rides along the percent divider
    typedef struct packed {
        logic                valid;
        logic [LEVEL_W-1:0]  level;
        logic [1:0]          min_rc;
        logic [RAISED_W-1:0] raised;
    } tag_t;

    // One register write or marker
    typedef struct packed {
        target_t     target;
        logic [31:0] value;
    } item_t;

    // FLF increment per speed level
    function automatic logic [8:0] step_of(input logic [LEVEL_W-1:0] lv);
        logic [8:0] s;
        begin
            case (lv)
                3'd1:    s = 9'd50;
                3'd2:    s = 9'd150;
                3'd3:    s = 9'd235;
                3'd4:    s = 9'd345;
                default: s = 9'd0;
            endcase
            return s;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cpws_divider.sv =====
// ----------------------------------------------------------------------------
// cpws_divider
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none

module cpws_divider import cpws_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire tag_t               in_tag,
    input  wire logic [NUM_W-1:0]   in_num,
    input  wire logic [FLF_W-1:0]   in_den,
    output tag_t                    out_tag,
    output logic [QUO_W-1:0]        out_quo
);

    localparam int STAGES = QUO_W;

    tag_t             tag_reg  [STAGES+1];
    logic [FLF_W-1:0] rem_reg  [STAGES+1];
    logic [QUO_W-1:0] low_reg  [STAGES+1];
    logic [QUO_W-1:0] quo_reg  [STAGES+1];
    logic [FLF_W-1:0] den_reg  [STAGES+1];

    tag_t             tag_next [STAGES+1];
    logic [FLF_W-1:0] rem_next [STAGES+1];
    logic [QUO_W-1:0] low_next [STAGES+1];
    logic [QUO_W-1:0] quo_next [STAGES+1];
    logic [FLF_W-1:0] den_next [STAGES+1];

    logic [FLF_W:0]   trial    [STAGES+1];
    logic [FLF_W:0]   diff     [STAGES+1];
    logic             ge       [STAGES+1];

    // Load: the quotient fits 16 bits, so the top numerator bits seed the remainder
    always_comb begin
        tag_next[0] = in_tag;
        rem_next[0] = FLF_W'(in_num[NUM_W-1:QUO_W]);
        low_next[0] = in_num[QUO_W-1:0];
        quo_next[0] = '0;
        den_next[0] = in_den;
        trial[0]    = '0;
        diff[0]     = '0;
        ge[0]       = 1'b0;
        for (int k = 1; k <= STAGES; k++) begin
            trial[k]    = {rem_reg[k-1], low_reg[k-1][QUO_W-1]};
            diff[k]     = trial[k] - {1'b0, den_reg[k-1]};
            ge[k]       = trial[k] >= {1'b0, den_reg[k-1]};
            rem_next[k] = ge[k] ? diff[k][FLF_W-1:0] : trial[k][FLF_W-1:0];
            low_next[k] = {low_reg[k-1][QUO_W-2:0], 1'b0};
            quo_next[k] = {quo_reg[k-1][QUO_W-2:0], ge[k]};
            tag_next[k] = tag_reg[k-1];
            den_next[k] = den_reg[k-1];
        end
    end

    // Advance all stages together
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= STAGES; k++) begin
                tag_reg[k] <= '0;
            end
        end else if (en) begin
            for (int k = 0; k <= STAGES; k++) begin
                tag_reg[k] <= tag_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k <= STAGES; k++) begin
                rem_reg[k] <= rem_next[k];
                low_reg[k] <= low_next[k];
                quo_reg[k] <= quo_next[k];
                den_reg[k] <= den_next[k];
            end
        end
    end

    assign out_tag = tag_reg[STAGES];
    assign out_quo = quo_reg[STAGES];

endmodule

`default_nettype wire

// ===== rtl/clock_preset_write_sequencer.sv =====
// Each request carries a speed level (0..7, above 5 taken as 5) and yields an
// ordered burst of 1 to 7 result items: register writes for the frequency
// control, FLL and SDRAM wait registers, mode-set markers and FLL lock waits,
// built from the boot snapshots in the configuration registers. The last item
// of a burst carries the rounded new clock in percent. A request travels
// through two front stages and a 17-stage percent divider, then loads the
// burst register; the result channel drains that register at one item per
// cycle while m_tready is high, and the whole pipeline holds while a burst
// is still draining, so the next burst loads in the cycle its predecessor's
// last item is taken.
// ----------------------------------------------------------------------------
// clock_preset_write_sequencer
// Speed level to clock and SDRAM register write sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_preset_write_sequencer import cpws_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write port
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [31:0] cfg_wdata,
    // Request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [2:0] level
    // Result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [2:0]       m_tuser,   // [2:0] target
    output logic [47:0]      m_tdata,   // [31:0] write_value, [47:32] speed_percent
    output logic             m_tlast
);

    `include "clock_preset_write_sequencer_defines.svh"

    // Configuration registers
    logic [31:0] boot_freq_reg;
    logic [31:0] boot_fll_reg;
    logic [31:0] boot_wait_reg;
    logic        snapshot_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            boot_freq_reg      <= '0;
            boot_fll_reg       <= '0;
            boot_wait_reg      <= '0;
            snapshot_valid_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                REG_FREQ_CTRL:  boot_freq_reg      <= cfg_wdata;
                REG_FLL_FREQ:   boot_fll_reg       <= cfg_wdata;
                REG_SDRAM_WAIT: boot_wait_reg      <= cfg_wdata;
                REG_SNAP_VALID: snapshot_valid_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Fields of the snapshots
    logic [FLF_W-1:0] base;
    logic             dbl;
    logic [5:0]       pll;
    logic [2:0]       bdiv;

    assign base = boot_fll_reg[FLF_W-1:0];
    assign dbl  = boot_fll_reg[14];
    assign pll  = boot_freq_reg[29:24];
    assign bdiv = boot_freq_reg[10:8];

    // Pipeline advance: burst register empty or giving up its last item
    logic [CNT_W-1:0] cnt_reg;
    logic             adv;

    assign adv      = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && m_tready);
    assign s_tready = adv;

    // Stage 1: capture request, clamp level
    logic               s1_valid_reg;
    logic [LEVEL_W-1:0] s1_level_reg;
    logic [LEVEL_W-1:0] s1_level_next;

    assign s1_level_next = (s_tdata[LEVEL_W-1:0] > MAX_LEVEL) ? MAX_LEVEL
                                                              : s_tdata[LEVEL_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_level_reg <= s1_level_next;
        end
    end

    // Stage 2: raised multiplier, percent numerator product, bus product
    logic                s2_valid_reg;
    logic [LEVEL_W-1:0]  s2_level_reg;
    logic [RAISED_W-1:0] s2_raised_reg;
    logic [NUM_W-1:0]    s2_prod_reg;
    logic [NUM_W-1:0]    s2_bus_reg;

    logic [RAISED_W-1:0] raised_sum;
    logic [RAISED_W-1:0] s2_raised_next;
    logic [RAISED_W-1:0] flf_eff;
    logic [6:0]          pll_mul;
    logic [21:0]         prod_full;
    logic [21:0]         bus_full;

    always_comb begin
        raised_sum     = RAISED_W'(base) + RAISED_W'(step_of(s1_level_reg));
        s2_raised_next = (!dbl && (raised_sum > FLF_CAP_SINGLE)) ? FLF_CAP_SINGLE
                                                                 : raised_sum;
        flf_eff        = dbl ? {base, 1'b0} : {1'b0, base};
        pll_mul        = {1'b0, pll} + 7'd1;
        prod_full      = 22'(s2_raised_next) * PCT_SCALE;
        bus_full       = 22'(flf_eff) * 22'(pll_mul);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_level_reg  <= s1_level_reg;
            s2_raised_reg <= s2_raised_next;
            s2_prod_reg   <= prod_full[NUM_W-1:0];
            s2_bus_reg    <= bus_full[NUM_W-1:0];
        end
    end

    // Stage 3: rounding bias, bus frequency and minimum row cycle
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] bus;
    logic [3:0]       bus_shift;
    logic [1:0]       min_rc;
    tag_t             dv_in_tag;

    always_comb begin
        num       = s2_prod_reg + NUM_W'(base >> 1);
        bus_shift = {1'b0, bdiv} + 4'd1;
        bus       = s2_bus_reg >> bus_shift;
        if (bus >= BUS_RC3) begin
            min_rc = 2'd3;
        end else if (bus >= BUS_RC2) begin
            min_rc = 2'd2;
        end else if (bus >= BUS_RC1) begin
            min_rc = 2'd1;
        end else begin
            min_rc = 2'd0;
        end
        dv_in_tag.valid  = s2_valid_reg;
        dv_in_tag.level  = s2_level_reg;
        dv_in_tag.min_rc = min_rc;
        dv_in_tag.raised = s2_raised_reg;
    end

    // Percent division
    tag_t             dv_tag;
    logic [QUO_W-1:0] dv_quo;

    cpws_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .in_tag  (dv_in_tag),
        .in_num  (num),
        .in_den  (base),
        .out_tag (dv_tag),
        .out_quo (dv_quo)
    );

    // Build the burst for the request leaving the divider
    item_t            burst      [MAX_ITEMS];
    logic [CNT_W-1:0] burst_n;
    logic [PCT_W-1:0] burst_pct;
    logic [FLF_W-1:0] wr_flf;
    logic [31:0]      w_tight;
    logic [1:0]       cl;

    always_comb begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            burst[i] = '{target: TGT_NONE, value: 32'd0};
        end
        burst_n   = '0;
        burst_pct = PCT_DEFAULT;
        cl        = boot_wait_reg[8:7];
        wr_flf    = (dv_tag.raised > FLF_CAP) ? FLF_CAP[FLF_W-1:0]
                                              : dv_tag.raised[FLF_W-1:0];
        w_tight   = boot_wait_reg;
        if (!snapshot_valid_reg) begin
            burst_n = CNT_W'(1);
        end else begin
            burst[burst_n] = '{target: TGT_FREQ, value: boot_freq_reg};
            burst_n = burst_n + CNT_W'(1);
            if (dv_tag.level == LEVEL_DEFAULT) begin
                // Boot clock, then tighten SDRAM timing
                burst[burst_n] = '{target: TGT_FLL, value: boot_fll_reg};
                burst_n = burst_n + CNT_W'(1);
                burst[burst_n] = '{target: TGT_LOCK, value: 32'd0};
                burst_n = burst_n + CNT_W'(1);
                if (cl == CAS_CODE_CL3) begin
                    w_tight = (boot_wait_reg & ~CAS_MASK) | CAS_CL2_BITS;
                    burst[burst_n] = '{target: TGT_WAIT, value: w_tight};
                    burst_n = burst_n + CNT_W'(1);
                    burst[burst_n] = '{target: TGT_MRS2, value: 32'd0};
                    burst_n = burst_n + CNT_W'(1);
                end
                if (w_tight[1:0] > dv_tag.min_rc) begin
                    burst[burst_n] = '{target: TGT_WAIT,
                                       value: {w_tight[31:2], dv_tag.min_rc}};
                    burst_n = burst_n + CNT_W'(1);
                end
            end else begin
                // Restore boot SDRAM timing
                burst[burst_n] = '{target: TGT_WAIT, value: boot_wait_reg};
                burst_n = burst_n + CNT_W'(1);
                if (cl == CAS_CODE_CL2) begin
                    burst[burst_n] = '{target: TGT_MRS2, value: 32'd0};
                    burst_n = burst_n + CNT_W'(1);
                end else if (cl == CAS_CODE_CL3) begin
                    burst[burst_n] = '{target: TGT_MRS3, value: 32'd0};
                    burst_n = burst_n + CNT_W'(1);
                end
                if (dv_tag.level == MAX_LEVEL) begin
                    // Turbo: doubling bit and turbo timing
                    burst[burst_n] = '{target: TGT_WAIT, value: TURBO_WAIT};
                    burst_n = burst_n + CNT_W'(1);
                    burst[burst_n] = '{target: TGT_MRS2, value: 32'd0};
                    burst_n = burst_n + CNT_W'(1);
                    burst[burst_n] = '{target: TGT_FLL,
                                       value: (boot_fll_reg & ~FLL_LOW_MASK) | FLL_DBL_BIT
                                              | 32'(base)};
                    burst_n = burst_n + CNT_W'(1);
                    if (base != '0) begin
                        burst_pct = PCT_TURBO;
                    end
                end else begin
                    // FLF step
                    burst[burst_n] = '{target: TGT_FLL,
                                       value: (boot_fll_reg & ~FLF_MASK) | 32'(wr_flf)};
                    burst_n = burst_n + CNT_W'(1);
                    if (base != '0) begin
                        burst_pct = dv_quo;
                    end
                end
                burst[burst_n] = '{target: TGT_LOCK, value: 32'd0};
                burst_n = burst_n + CNT_W'(1);
            end
        end
    end

    // Burst register: load a new burst or shift out the head item
    item_t            frame_reg  [MAX_ITEMS];
    item_t            frame_next [MAX_ITEMS];
    logic [CNT_W-1:0] cnt_next;
    logic [PCT_W-1:0] pct_reg;
    logic             m_hs;

    assign m_hs = m_tvalid && m_tready;

    always_comb begin
        cnt_next = cnt_reg;
        for (int i = 0; i < MAX_ITEMS; i++) begin
            frame_next[i] = frame_reg[i];
        end
        if (adv) begin
            cnt_next = dv_tag.valid ? burst_n : '0;
            for (int i = 0; i < MAX_ITEMS; i++) begin
                frame_next[i] = burst[i];
            end
        end else if (m_hs) begin
            cnt_next = cnt_reg - CNT_W'(1);
            for (int i = 0; i < MAX_ITEMS - 1; i++) begin
                frame_next[i] = frame_reg[i+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            frame_reg[i] <= frame_next[i];
        end
        if (adv) begin
            pct_reg <= burst_pct;
        end
    end

    // Result channel
    logic [PCT_W-1:0] pct_out;

    assign m_tvalid = cnt_reg != '0;
    assign m_tlast  = cnt_reg == CNT_W'(1);
    assign pct_out  = m_tlast ? pct_reg : '0;
    assign m_tuser  = frame_reg[0].target;
    assign m_tdata  = {pct_out, frame_reg[0].value};

    // Checks
    `CPWS_ASSERT_NEXT(a_burst_loads, adv && dv_tag.valid, m_tvalid,
        "burst not presented after load")
    `CPWS_ASSERT_SAME(a_level_clamped, dv_tag.valid, dv_tag.level <= MAX_LEVEL,
        "unclamped level reached the burst stage")
    `CPWS_ASSERT_NEXT(a_no_snapshot_single, adv && dv_tag.valid && !snapshot_valid_reg,
        cnt_reg == CNT_W'(1), "request without snapshot must give one item")
    `CPWS_ASSERT_SAME(a_none_is_last, m_tvalid && (frame_reg[0].target == TGT_NONE),
        m_tlast, "empty item must end its burst")

endmodule

`default_nettype wire
